// ----- rtl/instruction_argument_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the instruction argument decoder
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_ARGUMENT_DECODER_ASSERT_SVH
`define INSTRUCTION_ARGUMENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define IAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iad_pkg.sv -----
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types and constants of the instruction argument decoder.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam int OPCODE_W    = 5;
    localparam int WIN_HIGH_W  = 56;
    localparam int WIN_LOW_W   = 48;
    localparam int VALUE_W     = 32;
    localparam int LENGTH_W    = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    typedef logic [1:0] arg_kind_t;

    localparam arg_kind_t KIND_NONE = 2'd0;
    localparam arg_kind_t KIND_REG  = 2'd1;
    localparam arg_kind_t KIND_DIR  = 2'd2;
    localparam arg_kind_t KIND_IND  = 2'd3;

    // Argument codes in the coding byte
    localparam logic [1:0] CODE_REG = 2'd1;
    localparam logic [1:0] CODE_DIR = 2'd2;
    localparam logic [1:0] CODE_IND = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_CODING_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_DIRECT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARG_COUNT       = 2'd2;

    localparam logic [15:0] HAS_CODING_BYTE_RESET = 16'hB6FE;
    localparam logic [15:0] SHORT_DIRECT_RESET    = 16'h6F00;
    localparam logic [31:0] ARG_COUNT_RESET       = 32'd1585315817;

endpackage

// ----- rtl/iad_if.sv -----
// ----------------------------------------------------------------------------
// iad_req_if / iad_res_if
// Valid/ready channels carrying decode requests and decoded instructions.
// ----------------------------------------------------------------------------
interface iad_req_if;
    import iad_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [WIN_HIGH_W-1:0] window_high;
    logic [WIN_LOW_W-1:0]  window_low;

    modport source (output valid, output opcode, output window_high, output window_low,
                    input ready);
    modport sink   (input valid, input opcode, input window_high, input window_low,
                    output ready);
endinterface

interface iad_res_if;
    import iad_pkg::*;

    logic               valid;
    logic               ready;
    logic [LENGTH_W-1:0] total_length;
    arg_kind_t          first_kind;
    logic [VALUE_W-1:0] first_value;
    arg_kind_t          second_kind;
    logic [VALUE_W-1:0] second_value;
    arg_kind_t          third_kind;
    logic [VALUE_W-1:0] third_value;

    modport source (output valid, output total_length,
                    output first_kind, output first_value,
                    output second_kind, output second_value,
                    output third_kind, output third_value,
                    input ready);
    modport sink   (input valid, input total_length,
                    input first_kind, input first_value,
                    input second_kind, input second_value,
                    input third_kind, input third_value,
                    output ready);
endinterface

// ----- rtl/instruction_argument_decoder.sv -----
// ----------------------------------------------------------------------------
// instruction_argument_decoder
// Decodes the argument kinds, values and byte length of one instruction.
// A request (item) carries the opcode and the 13 bytes after it; a result
// (result) gives total length plus kind and value of three arguments.
// A request passes an input register, the decode logic, then the result
// register. One request is taken every cycle while results are taken.
// The result register holds while the receiver stalls. The input register
// takes a request whenever it is empty or its contents move on, so one more
// request is accepted while a finished result waits, then item.ready drops.
// Reset empties both stages and loads the default opcode tables into the
// configuration registers; cfg_we writes one of them per cycle. The user must
// write them only when idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module instruction_argument_decoder #(
    parameter int INDIRECT_BYTES = 2,
    parameter int DIRECT_BYTES   = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [iad_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [iad_pkg::CFG_DATA_W-1:0]       cfg_data,
    iad_req_if.sink                              item,
    iad_res_if.source                            result
);
    import iad_pkg::*;

    `include "instruction_argument_decoder_assert.svh"

    localparam logic [2:0] IND_BYTES = 3'(INDIRECT_BYTES);
    localparam logic [2:0] DIR_BYTES = 3'(DIRECT_BYTES);
    localparam int         WIN_W     = WIN_HIGH_W + WIN_LOW_W + VALUE_W;

    // Configuration
    logic [15:0] has_cb_mask_reg;
    logic [15:0] short_dir_mask_reg;
    logic [31:0] arg_count_reg;

    // Input stage
    logic                  s1_valid_reg;
    logic [OPCODE_W-1:0]   s1_opcode_reg;
    logic [WIN_HIGH_W-1:0] s1_win_high_reg;
    logic [WIN_LOW_W-1:0]  s1_win_low_reg;

    // Result stage
    logic                res_valid_reg;
    logic [LENGTH_W-1:0] res_length_reg;
    arg_kind_t           res_kind_reg  [3];
    logic [VALUE_W-1:0]  res_value_reg [3];

    logic                res_valid_next;
    logic                s1_valid_next;
    logic                s2_take;
    logic                item_accept;
    logic                s1_move;

    // Decode signals
    logic                op_valid;
    logic [3:0]          op_idx;
    logic                has_cb;
    logic                short_dir;
    logic [1:0]          count_raw;
    logic [1:0]          count_eff;
    logic [2:0]          dir_len;
    logic [7:0]          coding_byte;
    logic [1:0]          code      [3];
    arg_kind_t           kind_w    [3];
    logic [2:0]          size_w    [3];
    logic [3:0]          pos_w     [3];
    logic [VALUE_W-1:0]  value_w   [3];
    logic [LENGTH_W-1:0] length_w;
    logic [WIN_W-1:0]    window;

    function automatic logic [VALUE_W-1:0] read_value(
        input logic [WIN_W-1:0] win,
        input logic [3:0]       start,
        input logic [2:0]       size
    );
        logic [WIN_W-1:0]   shifted;
        logic [VALUE_W-1:0] chunk;
        logic [2:0]         drop;
        begin
            // byte one sits at the top of the window
            shifted = win << {start - 4'd1, 3'b000};
            chunk   = shifted[WIN_W-1 -: VALUE_W];
            drop    = 3'd4 - size;
            return chunk >> {drop, 3'b000};
        end
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s2_take     = !res_valid_reg || result.ready;
    assign item.ready  = !s1_valid_reg || s2_take;
    assign item_accept = item.valid && item.ready;
    assign s1_move     = s1_valid_reg && s2_take;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s2_take)
        begin
            res_valid_next = s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_cb_mask_reg    <= HAS_CODING_BYTE_RESET;
            short_dir_mask_reg <= SHORT_DIRECT_RESET;
            arg_count_reg      <= ARG_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HAS_CODING_BYTE: has_cb_mask_reg    <= cfg_data[15:0];
                CFG_SHORT_DIRECT:    short_dir_mask_reg <= cfg_data[15:0];
                CFG_ARG_COUNT:       arg_count_reg      <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign window      = {s1_win_high_reg, s1_win_low_reg, {VALUE_W{1'b0}}};
    assign op_valid    = (s1_opcode_reg != '0) && (s1_opcode_reg <= 5'd16);
    assign op_idx      = 4'(s1_opcode_reg - 5'd1);
    assign has_cb      = has_cb_mask_reg[op_idx];
    assign short_dir   = short_dir_mask_reg[op_idx];
    assign count_raw   = arg_count_reg[{op_idx, 1'b0} +: 2];
    assign count_eff   = (count_raw == 2'd0) ? 2'd1 : count_raw;
    assign dir_len     = short_dir ? IND_BYTES : DIR_BYTES;
    assign coding_byte = s1_win_high_reg[WIN_HIGH_W-1 -: 8];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            code[i]   = coding_byte[7 - 2*i -: 2];
            kind_w[i] = KIND_NONE;
            size_w[i] = 3'd0;
            if (!op_valid)
            begin
                kind_w[i] = KIND_NONE;
            end
            else if (!has_cb)
            begin
                if (i == 0)
                begin
                    kind_w[i] = KIND_DIR;
                    size_w[i] = dir_len;
                end
            end
            else if (2'(i) < count_eff)
            begin
                case (code[i])
                    CODE_REG:
                    begin
                        kind_w[i] = KIND_REG;
                        size_w[i] = 3'd1;
                    end
                    CODE_DIR:
                    begin
                        kind_w[i] = KIND_DIR;
                        size_w[i] = dir_len;
                    end
                    CODE_IND:
                    begin
                        kind_w[i] = KIND_IND;
                        size_w[i] = IND_BYTES;
                    end
                    default:
                    begin
                        kind_w[i] = KIND_NONE;
                        size_w[i] = 3'd0;
                    end
                endcase
            end
        end

        // arguments follow the coding byte (or the opcode) back to back
        pos_w[0] = has_cb ? 4'd2 : 4'd1;
        pos_w[1] = pos_w[0] + 4'(size_w[0]);
        pos_w[2] = pos_w[1] + 4'(size_w[1]);

        for (int i = 0; i < 3; i++)
        begin
            value_w[i] = read_value(window, pos_w[i], size_w[i]);
        end

        if (op_valid)
        begin
            length_w = pos_w[2] + 4'(size_w[2]) - 4'd1;
        end
        else
        begin
            length_w = '0;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_opcode_reg   <= item.opcode;
            s1_win_high_reg <= item.window_high;
            s1_win_low_reg  <= item.window_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_length_reg <= length_w;
            for (int i = 0; i < 3; i++)
            begin
                res_kind_reg[i]  <= kind_w[i];
                res_value_reg[i] <= value_w[i];
            end
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.total_length = res_length_reg;
    assign result.first_kind   = res_kind_reg[0];
    assign result.first_value  = res_value_reg[0];
    assign result.second_kind  = res_kind_reg[1];
    assign result.second_value = res_value_reg[1];
    assign result.third_kind   = res_kind_reg[2];
    assign result.third_value  = res_value_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IAD_ASSERT_NOW(a_first_none_zero, clk, rst_n,
        res_valid_reg && (res_kind_reg[0] == KIND_NONE), res_value_reg[0] == '0,
        "first argument of kind none carries a value")
    `IAD_ASSERT_NOW(a_second_none_zero, clk, rst_n,
        res_valid_reg && (res_kind_reg[1] == KIND_NONE), res_value_reg[1] == '0,
        "second argument of kind none carries a value")
    `IAD_ASSERT_NOW(a_third_none_zero, clk, rst_n,
        res_valid_reg && (res_kind_reg[2] == KIND_NONE), res_value_reg[2] == '0,
        "third argument of kind none carries a value")
    `IAD_ASSERT_NOW(a_length_bound, clk, rst_n,
        res_valid_reg, res_length_reg <= 4'd13,
        "instruction length beyond the byte window")
    `IAD_ASSERT_NEXT(a_stage_moves, clk, rst_n,
        s1_move, res_valid_reg,
        "decoded request lost between input and result registers")

endmodule

// ----- test/instruction_argument_decoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// instruction_argument_decoder_test
// Self-checking bench for the argument decoder. Requests come from a queue
// filled by the stimulus process, each accepted request is decoded by a
// predictor and the decoded instruction is compared field by field against
// the result channel. The opcode tables are rewritten between phases.
// ----------------------------------------------------------------------------
module instruction_argument_decoder_test;
    import iad_pkg::*;

    localparam int INDIRECT_BYTES = 2;
    localparam int DIRECT_BYTES   = 4;
    localparam int STALL_PERCENT  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [WIN_HIGH_W-1:0] window_high;
        logic [WIN_LOW_W-1:0]  window_low;
    } request_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] total_length;
        arg_kind_t           first_kind;
        logic [VALUE_W-1:0]  first_value;
        arg_kind_t           second_kind;
        logic [VALUE_W-1:0]  second_value;
        arg_kind_t           third_kind;
        logic [VALUE_W-1:0]  third_value;
    } decoded_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    iad_req_if req_bus ();
    iad_res_if res_bus ();

    instruction_argument_decoder #(
        .INDIRECT_BYTES (INDIRECT_BYTES),
        .DIRECT_BYTES   (DIRECT_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (req_bus),
        .result    (res_bus)
    );

    // Local copy of the opcode tables
    logic [15:0] coding_byte_ops;
    logic [15:0] short_direct_ops;
    logic [31:0] arg_counts;

    request_t request_q[$];
    decoded_t decoded_q[$];

    int  mismatches;
    bit  request_taken;
    bit  steady;
    int  idle_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic decoded_t decode_instruction(request_t req);
        logic [103:0] window;
        arg_kind_t    kind [3];
        int unsigned  width [3];
        logic [31:0]  value [3];
        int unsigned  idx;
        int unsigned  count;
        int unsigned  dir_bytes;
        int unsigned  pos;
        int unsigned  length;
        int unsigned  k;
        logic [7:0]   coding;
        logic [7:0]   b;
        logic [1:0]   code;
        decoded_t     d;

        window = {req.window_high, req.window_low};
        d = '0;
        length = 0;
        for (int i = 0; i < 3; i++)
        begin
            kind[i]  = KIND_NONE;
            width[i] = 0;
            value[i] = '0;
        end
        if (req.opcode >= 1 && req.opcode <= 16)
        begin
            idx = req.opcode - 1;
            count = {30'd0, arg_counts[2*idx +: 2]};
            dir_bytes = short_direct_ops[idx] ? INDIRECT_BYTES : DIRECT_BYTES;
            if (!coding_byte_ops[idx])
            begin
                kind[0]  = KIND_DIR;
                width[0] = dir_bytes;
                pos = 1;
            end
            else
            begin
                coding = window[103:96];
                // a zero count still decodes the first argument
                if (count == 0)
                    count = 1;
                for (int i = 0; i < 3; i++)
                begin
                    if (i < count)
                    begin
                        code = coding[7-2*i -: 2];
                        case (code)
                            CODE_REG:
                            begin
                                kind[i]  = KIND_REG;
                                width[i] = 1;
                            end
                            CODE_DIR:
                            begin
                                kind[i]  = KIND_DIR;
                                width[i] = dir_bytes;
                            end
                            CODE_IND:
                            begin
                                kind[i]  = KIND_IND;
                                width[i] = INDIRECT_BYTES;
                            end
                            default: ;
                        endcase
                    end
                end
                pos = 2;
            end
            length = pos - 1;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < width[i] && j < 4; j++)
                begin
                    k = pos + j;
                    b = (k >= 1 && k <= 13) ? window[(13-k)*8 +: 8] : 8'h00;
                    value[i] = {value[i][23:0], b};
                end
                pos    += width[i];
                length += width[i];
            end
        end
        d.total_length = length[LENGTH_W-1:0];
        d.first_kind   = kind[0];
        d.first_value  = value[0];
        d.second_kind  = kind[1];
        d.second_value = value[1];
        d.third_kind   = kind[2];
        d.third_value  = value[2];
        return d;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            CFG_HAS_CODING_BYTE: coding_byte_ops  = data[15:0];
            CFG_SHORT_DIRECT:    short_direct_ops = data[15:0];
            CFG_ARG_COUNT:       arg_counts       = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_tables(logic [15:0] coding, logic [15:0] short_dir, logic [31:0] counts);
        write_register(CFG_HAS_CODING_BYTE, {16'h0, coding});
        write_register(CFG_SHORT_DIRECT, {16'h0, short_dir});
        write_register(CFG_ARG_COUNT, counts);
    endtask

    task automatic add_request(logic [OPCODE_W-1:0] op, logic [WIN_HIGH_W-1:0] hi,
                               logic [WIN_LOW_W-1:0] lo);
        request_t req;
        req.opcode      = op;
        req.window_high = hi;
        req.window_low  = lo;
        request_q.push_back(req);
    endtask

    task automatic add_random_requests(int n);
        logic [63:0]         hi_bits;
        logic [63:0]         lo_bits;
        logic [OPCODE_W-1:0] op;
        for (int i = 0; i < n; i++)
        begin
            hi_bits = {$urandom, $urandom};
            lo_bits = {$urandom, $urandom};
            // mostly real opcodes, now and then any five-bit opcode, possibly outside the table
            if ($urandom_range(99) < 90)
                op = OPCODE_W'($urandom_range(16, 1));
            else
                op = OPCODE_W'($urandom_range(31));
            add_request(op, hi_bits[WIN_HIGH_W-1:0], lo_bits[WIN_LOW_W-1:0]);
        end
    endtask

    task automatic drain();
        while (request_q.size() != 0 || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: a held request stays on the bus until taken
    always @(negedge clk)
    begin
        if (rst_n && !(req_bus.valid && !request_taken))
        begin
            if (request_q.size() != 0 && (steady || $urandom_range(99) >= STALL_PERCENT))
            begin
                req_bus.valid       <= 1'b1;
                req_bus.opcode      <= request_q[0].opcode;
                req_bus.window_high <= request_q[0].window_high;
                req_bus.window_low  <= request_q[0].window_low;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Receiver, with long hold-offs so the block backs up into its input
    int rx_cycles;
    int hold_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles == 300 || rx_cycles == 1200)
                hold_left = 150;
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= steady || $urandom_range(99) >= STALL_PERCENT;
        end
    end

    // Monitor: predicts on each accepted request, checks each result
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n)
        begin
            request_taken = req_bus.valid && req_bus.ready;
            if (request_taken)
            begin
                decoded_q.push_back(decode_instruction(request_q[0]));
                void'(request_q.pop_front());
            end
            if (res_bus.valid && res_bus.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual length %0h",
                             $time, res_bus.total_length);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("total_length", want.total_length, res_bus.total_length);
                    check_field("first_kind", want.first_kind, res_bus.first_kind);
                    check_field("first_value", want.first_value, res_bus.first_value);
                    check_field("second_kind", want.second_kind, res_bus.second_kind);
                    check_field("second_value", want.second_value, res_bus.second_value);
                    check_field("third_kind", want.third_kind, res_bus.third_kind);
                    check_field("third_value", want.third_value, res_bus.third_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] coding_patterns [8];

        coding_patterns = '{8'h54, 8'hA8, 8'hFC, 8'h00, 8'hE4, 8'h1B, 8'hC4, 8'hFF};
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_HAS_CODING_BYTE;
        cfg_data            = '0;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = '0;
        req_bus.window_high = '0;
        req_bus.window_low  = '0;
        res_bus.ready       = 1'b0;
        mismatches          = 0;
        request_taken       = 0;
        steady              = 0;
        idle_cycles         = 0;
        rx_cycles           = 0;
        hold_left           = 0;
        coding_byte_ops     = HAS_CODING_BYTE_RESET;
        short_direct_ops    = SHORT_DIRECT_RESET;
        arg_counts          = ARG_COUNT_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every opcode once, coding bytes covering each code and the unknown one
        for (int op = 1; op <= 16; op++)
            add_request(OPCODE_W'(op), {coding_patterns[op % 8], 48'h0123_4567_89AB},
                        48'hCDEF_0123_4567);
        add_request(5'd1, '1, '1);
        add_request(5'd16, '1, '1);
        add_request(5'd16, '0, '0);
        // opcodes outside the table
        add_request(5'd0, '1, '1);
        add_request(5'd17, {8'h54, 48'hFFFF_FFFF_FFFF}, '1);
        add_request(5'd31, '1, '1);
        add_random_requests(350);
        drain();

        set_tables(16'($urandom), 16'($urandom), $urandom);
        add_random_requests(235);
        drain();

        // no coding bytes, four-byte directs
        set_tables('0, '0, '0);
        add_random_requests(235);
        drain();

        // every table bit set, no random idling on either side
        steady = 1;
        set_tables('1, '1, '1);
        add_random_requests(235);
        drain();
        steady = 0;

        // coding bytes with an argument count of zero
        set_tables('1, '0, '0);
        add_random_requests(235);
        drain();

        set_tables(16'($urandom), 16'($urandom), $urandom);
        add_random_requests(235);
        drain();

        set_tables(HAS_CODING_BYTE_RESET, SHORT_DIRECT_RESET, ARG_COUNT_RESET);
        add_random_requests(235);
        drain();

        if (mismatches == 0 && decoded_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
